// ----- sv/cctc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cruise control throttle controller package
// Shared types, register indexes and reset values.
// ----------------------------------------------------------------------------
package cctc_pkg;

    localparam int VelW      = 11;
    localparam int ThrW      = 8;
    localparam int ErrCfgW   = 10;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 10;
    localparam int InDataW   = 16;
    localparam int OutDataW  = 24;

    localparam logic [ErrCfgW-1:0] CruiseMinVelRst = 10'd200;
    localparam logic [ThrW-1:0]    ThrottleMaxRst  = 8'd80;
    localparam logic [ThrW-1:0]    SmallStepRst    = 8'd10;
    localparam logic [ThrW-1:0]    BigStepRst      = 8'd30;
    localparam logic [ErrCfgW-1:0] FarErrorRst     = 10'd15;
    localparam logic [ErrCfgW-1:0] NearErrorRst    = 10'd10;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_CRUISE_MIN_VEL = 3'd0,
        CFG_THROTTLE_MAX   = 3'd1,
        CFG_SMALL_STEP     = 3'd2,
        CFG_BIG_STEP       = 3'd3,
        CFG_FAR_ERROR      = 3'd4,
        CFG_NEAR_ERROR     = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [ErrCfgW-1:0] cruise_min_velocity;
        logic [ThrW-1:0]    throttle_max;
        logic [ThrW-1:0]    small_step;
        logic [ThrW-1:0]    big_step;
        logic [ErrCfgW-1:0] far_error;
        logic [ErrCfgW-1:0] near_error;
    } cfg_t;

    typedef struct packed {
        logic                   gas_button;
        logic                   brake_button;
        logic                   cruise_button;
        logic                   engine_switch;
        logic                   top_gear_switch;
        logic signed [VelW-1:0] measured_velocity;
    } in_item_t;

    typedef struct packed {
        logic                   engine_on;
        logic                   gear_top;
        logic                   gas_on;
        logic                   brake_on;
        logic                   cruise_on;
        logic [ThrW-1:0]        throttle_level;
        logic signed [VelW-1:0] target_velocity;
    } state_t;

endpackage : cctc_pkg
`default_nettype wire

// ----- sv/cctc_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration register file
// Holds the six tuning registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module cctc_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic [cctc_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [cctc_pkg::CfgDataW-1:0] cfg_data,
    output cctc_pkg::cfg_t                     cfg
);
    import cctc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_CRUISE_MIN_VEL: cfg_next.cruise_min_velocity = cfg_data[ErrCfgW-1:0];
                CFG_THROTTLE_MAX:   cfg_next.throttle_max        = cfg_data[ThrW-1:0];
                CFG_SMALL_STEP:     cfg_next.small_step          = cfg_data[ThrW-1:0];
                CFG_BIG_STEP:       cfg_next.big_step            = cfg_data[ThrW-1:0];
                CFG_FAR_ERROR:      cfg_next.far_error           = cfg_data[ErrCfgW-1:0];
                CFG_NEAR_ERROR:     cfg_next.near_error          = cfg_data[ErrCfgW-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cruise_min_velocity <= CruiseMinVelRst;
            cfg_reg.throttle_max        <= ThrottleMaxRst;
            cfg_reg.small_step          <= SmallStepRst;
            cfg_reg.big_step            <= BigStepRst;
            cfg_reg.far_error           <= FarErrorRst;
            cfg_reg.near_error          <= NearErrorRst;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule : cctc_cfg_regs
`default_nettype wire

// ----- sv/cctc_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Control period step
// Works out the next controller state from the current state and one period.
// ----------------------------------------------------------------------------
module cctc_step (
    input  wire cctc_pkg::cfg_t     cfg,
    input  wire cctc_pkg::state_t   cur,
    input  wire cctc_pkg::in_item_t item,
    output cctc_pkg::state_t        nxt
);
    import cctc_pkg::*;

    logic                   latched;
    logic                   gas_on;
    logic                   arm;
    logic                   cruise_btn;
    logic                   engine_on;
    logic                   cruise_on;
    logic                   apply;
    logic signed [VelW-1:0] vel;
    logic signed [VelW-1:0] tgt;
    logic signed [VelW:0]   err;
    logic [VelW:0]          neg_err;
    logic [VelW-1:0]        mag;
    logic [ThrW:0]          gas_sum;
    logic [ThrW-1:0]        thr_base;
    logic [ThrW-1:0]        step;
    logic [ThrW:0]          up_sum;
    logic [ThrW-1:0]        up_val;
    logic [ThrW-1:0]        dn_val;
    logic [ThrW-1:0]        thr_out;

    always_comb
    begin
        vel     = item.measured_velocity;
        latched = cur.cruise_on & cur.engine_on;

        gas_on     = item.gas_button & cur.engine_on;
        cruise_btn = cur.cruise_on & ~item.brake_button & ~gas_on;
        arm        = item.cruise_button & cur.gear_top & ~gas_on & ~item.brake_button
                     & (vel >= $signed({1'b0, cfg.cruise_min_velocity}));

        if (item.engine_switch)
            engine_on = 1'b1;
        else if (vel == '0)
            engine_on = 1'b0;
        else
            engine_on = cur.engine_on;

        cruise_on = (cruise_btn | arm) & item.top_gear_switch;
        apply     = cruise_on & engine_on;

        gas_sum = {1'b0, cur.throttle_level} + {1'b0, cfg.small_step};
        if (gas_on && engine_on)
            thr_base = (gas_sum > {1'b0, cfg.throttle_max}) ? cfg.throttle_max
                                                            : gas_sum[ThrW-1:0];
        else
            thr_base = '0;

        tgt     = latched ? cur.target_velocity : vel;
        err     = {vel[VelW-1], vel} - {tgt[VelW-1], tgt};
        neg_err = -err;
        mag     = (err > 0) ? err[VelW-1:0] : neg_err[VelW-1:0];

        step   = ({1'b0, mag} > {2'b0, cfg.near_error}) ? cfg.big_step : cfg.small_step;
        up_sum = {1'b0, thr_base} + {1'b0, step};
        up_val = (up_sum > {1'b0, cfg.throttle_max}) ? cfg.throttle_max : up_sum[ThrW-1:0];
        dn_val = (thr_base > step) ? (thr_base - step) : '0;
        if (dn_val > cfg.throttle_max)
            dn_val = cfg.throttle_max;

        if (!apply)
            thr_out = thr_base;
        else if (err > 0)
            thr_out = ({1'b0, mag} > {2'b0, cfg.far_error}) ? '0 : dn_val;
        else
            thr_out = ({1'b0, mag} > {2'b0, cfg.far_error}) ? cfg.throttle_max : up_val;

        nxt.engine_on       = engine_on;
        nxt.gear_top        = item.top_gear_switch;
        nxt.gas_on          = gas_on;
        nxt.brake_on        = item.brake_button;
        nxt.cruise_on       = cruise_on;
        nxt.throttle_level  = thr_out;
        nxt.target_velocity = apply ? tgt : '0;
    end

endmodule : cctc_step
`default_nettype wire

// ----- sv/cruise_control_throttle_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cruise control throttle controller
// Turns one control period of pedal, switch and velocity inputs into one
// throttle command and status word.
//
// The slave stream carries one control period per transfer; the master
// stream returns exactly one result transfer for each. Tuning registers are
// written through the cfg channel, which is always ready; the user must write
// them only while the block is idle, as the block does not enforce it.
// An input transfer is registered, then the step logic works out the next
// state and the controller state and output register are updated together,
// so a result passes through the input register and then the state register
// before it is presented. One transfer per cycle is sustained while the
// receiver is ready; the combinational state update is what sets that rate.
// When the receiver stalls, the output register holds its result and the
// input register can still take one more transfer; after that s_axis_tready
// drops until the master side drains.
// Reset clears the controller state, both valid flags and restores the
// register reset values.
// ----------------------------------------------------------------------------
module cruise_control_throttle_controller (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // gas_button, brake_button, cruise_button, engine_switch, top_gear_switch,
    // measured_velocity[10:0]
    input  wire logic [cctc_pkg::InDataW-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // throttle_out[7:0], cruise_active, engine_running, gas_active,
    // brake_active, top_gear_on, reference_velocity[10:0]
    output logic [cctc_pkg::OutDataW-1:0]       m_axis_tdata,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [cctc_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [cctc_pkg::CfgDataW-1:0]  cfg_data
);
    import cctc_pkg::*;

    cfg_t     cfg;
    state_t   state_reg;
    state_t   state_next;
    in_item_t item_reg;
    in_item_t item_in;
    logic     in_valid_reg;
    logic     out_valid_reg;
    logic     advance;

    assign cfg_ready = 1'b1;

    cctc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cctc_step u_step (
        .cfg  (cfg),
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next)
    );

    always_comb
    begin
        item_in.gas_button        = s_axis_tdata[0];
        item_in.brake_button      = s_axis_tdata[1];
        item_in.cruise_button     = s_axis_tdata[2];
        item_in.engine_switch     = s_axis_tdata[3];
        item_in.top_gear_switch   = s_axis_tdata[4];
        item_in.measured_velocity = s_axis_tdata[15:5];
    end

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            item_reg <= item_in;
    end

    assign m_axis_tvalid = out_valid_reg;

    always_comb
    begin
        m_axis_tdata[7:0]   = state_reg.throttle_level;
        m_axis_tdata[8]     = state_reg.cruise_on;
        m_axis_tdata[9]     = state_reg.engine_on;
        m_axis_tdata[10]    = state_reg.gas_on;
        m_axis_tdata[11]    = state_reg.brake_on;
        m_axis_tdata[12]    = state_reg.gear_top;
        m_axis_tdata[23:13] = state_reg.target_velocity;
    end

    a_ref_needs_cruise: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[23:13] != '0)) |-> (m_axis_tdata[8] && m_axis_tdata[9]))
        else $error("reference velocity set without active cruise");

    a_idle_throttle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[10] && !(m_axis_tdata[8] && m_axis_tdata[9]))
        |-> (m_axis_tdata[7:0] == '0))
        else $error("throttle nonzero without gas or cruise");

    a_brake_cancels: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[11]) |-> !m_axis_tdata[8])
        else $error("cruise active while braking");

    a_state_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("controller state changed without a transfer");

endmodule : cruise_control_throttle_controller
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cruise control throttle controller testbench
// Drives control periods into the slave stream and predicts each throttle and
// status word with an in-bench model of the controller. Every result transfer
// is compared field by field with the oldest prediction. The tuning registers
// are rewritten between phases while the block is idle. Both stream sides idle
// at random, and one long receiver hold-off makes the block stall its input.
// ----------------------------------------------------------------------------
module testbench;

    import cctc_pkg::*;

    localparam int HoldOffCycles = 60;
    localparam int DrainCycles   = 12;
    localparam int PhaseItems    = 255;

    localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
    localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

    localparam cfg_t TuneReset = '{
        cruise_min_velocity: CruiseMinVelRst,
        throttle_max:        ThrottleMaxRst,
        small_step:          SmallStepRst,
        big_step:            BigStepRst,
        far_error:           FarErrorRst,
        near_error:          NearErrorRst
    };

    typedef struct packed {
        logic signed [VelW-1:0] reference_velocity;
        logic                   top_gear_on;
        logic                   brake_active;
        logic                   gas_active;
        logic                   engine_running;
        logic                   cruise_active;
        logic [ThrW-1:0]        throttle_out;
    } period_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    state_t         ctl = '0;
    cfg_t           tune = TuneReset;
    period_result_t expected_results[$];
    int             fail_count = 0;
    int             drive_vel = 0;
    logic           idle_enable = 1'b0;
    logic           hold_off_req = 1'b0;

    cruise_control_throttle_controller i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int raise_throttle(int base, int step);
        int sum;
        sum = base + step;
        return (sum > int'(tune.throttle_max)) ? int'(tune.throttle_max) : sum;
    endfunction

    function automatic int lower_throttle(int base, int step);
        return (base > step) ? base - step : 0;
    endfunction

    function automatic period_result_t advance_controller(in_item_t item);
        period_result_t res;
        int             vel;
        int             thr;
        int             err;
        logic           latched;
        vel = $signed(item.measured_velocity);
        latched = ctl.cruise_on & ctl.engine_on;

        ctl.brake_on = item.brake_button;
        ctl.gas_on   = item.gas_button & ctl.engine_on;
        if (ctl.brake_on || ctl.gas_on)
            ctl.cruise_on = 1'b0;
        if (item.cruise_button && ctl.gear_top && vel >= int'(tune.cruise_min_velocity)
                && !ctl.gas_on && !ctl.brake_on)
            ctl.cruise_on = 1'b1;

        if (item.engine_switch)
            ctl.engine_on = 1'b1;
        else if (vel == 0)
            ctl.engine_on = 1'b0;
        ctl.gear_top = item.top_gear_switch;
        if (!ctl.gear_top)
            ctl.cruise_on = 1'b0;

        thr = 0;
        if (ctl.gas_on && ctl.engine_on)
            thr = raise_throttle(int'(ctl.throttle_level), int'(tune.small_step));

        if (ctl.cruise_on && ctl.engine_on)
        begin
            if (!latched)
                ctl.target_velocity = item.measured_velocity;
            err = vel - int'($signed(ctl.target_velocity));
            if (err > 0)
            begin
                if (err > int'(tune.far_error))
                    thr = 0;
                else if (err > int'(tune.near_error))
                    thr = lower_throttle(thr, int'(tune.big_step));
                else
                    thr = lower_throttle(thr, int'(tune.small_step));
                if (thr > int'(tune.throttle_max))
                    thr = int'(tune.throttle_max);
            end
            else
            begin
                err = -err;
                if (err > int'(tune.far_error))
                    thr = int'(tune.throttle_max);
                else if (err > int'(tune.near_error))
                    thr = raise_throttle(thr, int'(tune.big_step));
                else
                    thr = raise_throttle(thr, int'(tune.small_step));
            end
        end
        else
            ctl.target_velocity = '0;
        ctl.throttle_level = ThrW'(thr);

        res.throttle_out       = ctl.throttle_level;
        res.cruise_active      = ctl.cruise_on;
        res.engine_running     = ctl.engine_on;
        res.gas_active         = ctl.gas_on;
        res.brake_active       = ctl.brake_on;
        res.top_gear_on        = ctl.gear_top;
        res.reference_velocity = ctl.target_velocity;
        return res;
    endfunction

    function automatic void update_tuning(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
        case (cfg_idx_t'(idx))
            CFG_CRUISE_MIN_VEL: tune.cruise_min_velocity = value;
            CFG_THROTTLE_MAX:   tune.throttle_max = value[ThrW-1:0];
            CFG_SMALL_STEP:     tune.small_step = value[ThrW-1:0];
            CFG_BIG_STEP:       tune.big_step = value[ThrW-1:0];
            CFG_FAR_ERROR:      tune.far_error = value;
            CFG_NEAR_ERROR:     tune.near_error = value;
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic in_item_t make_period(logic gas, logic brake, logic cruise,
                                             logic engine, logic gear, int vel);
        in_item_t item;
        item.gas_button        = gas;
        item.brake_button      = brake;
        item.cruise_button     = cruise;
        item.engine_switch     = engine;
        item.top_gear_switch   = gear;
        item.measured_velocity = VelW'(vel);
        return item;
    endfunction

    function automatic in_item_t random_period();
        in_item_t           item;
        logic [InDataW-1:0] raw;
        int                 step;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            step = $urandom_range(0, 40);
            drive_vel += step - 20;
            if (pick < 3)
            begin
                step = $urandom_range(0, 2047);
                drive_vel = step - 1024;
            end
            if (drive_vel > 1023)
                drive_vel = 1023;
            if (drive_vel < -1024)
                drive_vel = -1024;
            item = make_period($urandom_range(0, 99) < 5, $urandom_range(0, 99) < 4,
                               $urandom_range(0, 99) < 12, $urandom_range(0, 99) < 97,
                               $urandom_range(0, 99) < 92, drive_vel);
            if (!item.engine_switch && $urandom_range(0, 1) == 1)
                item.measured_velocity = '0;
        end
        else
        begin
            raw = InDataW'($urandom);
            item = raw;
            if (pick >= 97)
                item.measured_velocity = '0;
        end
        return item;
    endfunction

    task automatic send_period(input in_item_t item);
        int   gap;
        logic accepted;
        gap = idle_enable ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {item.measured_velocity, item.top_gear_switch, item.engine_switch,
                          item.cruise_button, item.brake_button, item.gas_button};
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = s_axis_tready;
            if (accepted)
                expected_results.push_back(advance_controller(item));
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
        logic accepted;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = cfg_ready;
            if (accepted)
                update_tuning(idx, value);
            @(posedge clk);
        end
    endtask

    task automatic load_tuning(input cfg_t setting);
        logic [1:0] pad;
        logic [CfgDataW-1:0] junk;
        pad = 2'($urandom_range(0, 3));
        junk = CfgDataW'($urandom);
        write_reg(CFG_CRUISE_MIN_VEL, setting.cruise_min_velocity);
        write_reg(CFG_THROTTLE_MAX, {pad, setting.throttle_max});
        write_reg(CFG_SMALL_STEP, {~pad, setting.small_step});
        write_reg(CFG_BIG_STEP, {pad, setting.big_step});
        write_reg(CFG_FAR_ERROR, setting.far_error);
        write_reg(CFG_NEAR_ERROR, setting.near_error);
        write_reg($urandom_range(0, 1) ? CfgIdxSpareHi : CfgIdxSpareLo, junk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic test_directed();
        idle_enable = 1'b1;
        send_period(make_period(0, 0, 0, 0, 0, 0));
        send_period(make_period(1, 0, 0, 0, 0, 0));
        send_period(make_period(0, 0, 0, 1, 1, 0));
        repeat (9) send_period(make_period(1, 0, 0, 1, 1, 50));
        send_period(make_period(1, 1, 0, 1, 1, 50));
        send_period(make_period(0, 0, 1, 1, 1, 199));
        send_period(make_period(0, 0, 1, 1, 1, 200));
        send_period(make_period(0, 0, 0, 1, 1, 195));
        send_period(make_period(0, 0, 0, 1, 1, 188));
        send_period(make_period(0, 0, 0, 1, 1, 184));
        send_period(make_period(0, 0, 0, 1, 1, 205));
        send_period(make_period(0, 0, 0, 1, 1, 212));
        send_period(make_period(0, 0, 0, 1, 1, 1023));
        send_period(make_period(0, 0, 0, 1, 1, -1024));
        send_period(make_period(1, 0, 1, 1, 1, 300));
        send_period(make_period(0, 0, 1, 1, 1, 300));
        send_period(make_period(0, 0, 0, 1, 0, 300));
        send_period(make_period(0, 0, 0, 0, 0, 100));
        send_period(make_period(0, 0, 0, 0, 1, 0));
        send_period(make_period(0, 0, 1, 0, 1, 500));
        send_period(make_period(0, 0, 0, 1, 1, 510));
        send_period(make_period(0, 0, 0, 1, 1, 500));
    endtask

    task automatic test_register_extremes();
        cfg_t setting;
        setting = '{cruise_min_velocity: '0, throttle_max: '1, small_step: 8'd1,
                    big_step: '1, far_error: '1, near_error: '0};
        wait_idle();
        load_tuning(setting);
        idle_enable = 1'b0;
        send_period(make_period(0, 0, 0, 1, 1, 0));
        send_period(make_period(0, 0, 1, 1, 1, 0));
        send_period(make_period(0, 0, 0, 1, 1, 3));
        send_period(make_period(0, 0, 0, 1, 1, -3));
        send_period(make_period(0, 0, 1, 1, 1, -5));
        wait_idle();
        setting.throttle_max = 8'd20;
        load_tuning(setting);
        send_period(make_period(0, 0, 0, 1, 1, -3));
        send_period(make_period(0, 0, 0, 1, 1, 0));
        send_period(make_period(0, 0, 0, 1, 0, -1));
        send_period(make_period(0, 0, 1, 1, 1, -1));
        send_period(make_period(0, 0, 1, 1, 1, 1023));
        send_period(make_period(1, 1, 1, 1, 1, -1024));
        wait_idle();
        load_tuning('1);
        send_period(make_period(0, 0, 1, 1, 1, 1023));
        send_period(make_period(0, 0, 1, 1, 1, 1023));
        send_period(make_period(1, 0, 0, 1, 1, 1023));
        send_period(make_period(1, 0, 0, 1, 1, 1022));
    endtask

    task automatic test_backpressure();
        wait_idle();
        load_tuning(TuneReset);
        idle_enable = 1'b0;
        drive_vel = 220;
        hold_off_req = 1'b1;
        repeat (40) send_period(random_period());
    endtask

    task automatic test_random_phases();
        cfg_t settings[7];
        int   total;
        settings[0] = TuneReset;
        settings[1] = '0;
        settings[2] = '1;
        settings[3] = '{cruise_min_velocity: 10'd100, throttle_max: 8'd200, small_step: 8'd5,
                        big_step: 8'd20, far_error: 10'd40, near_error: 10'd15};
        for (int i = 4; i < 7; i++)
        begin
            settings[i].cruise_min_velocity = ErrCfgW'($urandom_range(0, 1023));
            settings[i].throttle_max        = ThrW'($urandom_range(0, 255));
            settings[i].small_step          = ThrW'($urandom_range(0, 255));
            settings[i].big_step            = ThrW'($urandom_range(0, 255));
            settings[i].far_error           = ErrCfgW'($urandom_range(0, 60));
            settings[i].near_error          = ErrCfgW'($urandom_range(0, 40));
        end
        foreach (settings[i])
        begin
            wait_idle();
            load_tuning(settings[i]);
            drive_vel = int'(settings[i].cruise_min_velocity) + $urandom_range(0, 30);
            for (total = 0; total < PhaseItems; total++)
            begin
                if (total % 50 == 0)
                    idle_enable = ($urandom_range(0, 3) != 0);
                send_period(random_period());
            end
        end
    endtask

    initial
    begin : receiver
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HoldOffCycles) @(posedge clk);
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (idle_enable && $urandom_range(0, 3) == 0)
            begin
                stall = pick_gap() + 1;
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin : result_checker
        logic                taken;
        logic [OutDataW-1:0] word;
        period_result_t      got;
        period_result_t      want;
        forever
        begin
            @(negedge clk);
            taken = rst_n && m_axis_tvalid && m_axis_tready;
            word  = m_axis_tdata;
            @(posedge clk);
            if (taken)
            begin
                got = word;
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no control period outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("throttle_out", want.throttle_out, got.throttle_out);
                    check_field("cruise_active", want.cruise_active, got.cruise_active);
                    check_field("engine_running", want.engine_running, got.engine_running);
                    check_field("gas_active", want.gas_active, got.gas_active);
                    check_field("brake_active", want.brake_active, got.brake_active);
                    check_field("top_gear_on", want.top_gear_on, got.top_gear_on);
                    check_field("reference_velocity", want.reference_velocity,
                                got.reference_velocity);
                end
            end
        end
    end

    initial
    begin : watchdog
        #(20_000_000);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_extremes();
        test_backpressure();
        test_random_phases();
        wait_idle();
        repeat (DrainCycles) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
